// ===== rtl/particle_grid_distance_sum_core_assert.svh =====
// assertion macros used by rtl/pgds_scan.sv
`ifndef PARTICLE_GRID_DISTANCE_SUM_CORE_ASSERT_SVH
`define PARTICLE_GRID_DISTANCE_SUM_CORE_ASSERT_SVH
`ifndef SYNTHESIS
`define PGDS_ASSERT(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
        else $error("pgds assertion failed");
`define PGDS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("pgds assertion failed");
`else
`define PGDS_ASSERT(lbl, cond)
`define PGDS_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

// ===== rtl/pgds_pkg.sv =====
// types and constants of the particle grid distance sum block
`default_nettype none
package pgds_pkg;
    localparam int MAX_GRID     = 64;
    localparam int GRID_W       = 7;
    localparam int PITCH_W      = 17;
    localparam int RMAX_W       = 34;
    localparam int POS_W        = 16;
    localparam int SUM_W        = 35;
    localparam int COUNT_W      = 19;
    localparam int IDX_W        = 6;
    localparam int CTR_W        = 24;   // 2*idx*pitch + pitch
    localparam int DIFF_W       = 18;   // axis difference kept after far test
    localparam int SQ_W         = 2 * DIFF_W;
    localparam int ROOT_W       = 17;
    localparam int REM_W        = 19;
    localparam int SQRT_STAGES  = ROOT_W;
    localparam int CFG_IDX_W    = 2;
    localparam int CFG_DATA_W   = RMAX_W;

    localparam logic [CFG_IDX_W-1:0] CFG_GRID_CELLS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CELL_PITCH   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_RMAX_SQUARED = 2'd2;

    localparam logic [GRID_W-1:0]  GRID_RESET  = 7'd64;
    localparam logic [PITCH_W-1:0] PITCH_RESET = 17'd1024;
    localparam logic [RMAX_W-1:0]  RMAX_RESET  = 34'd171798692;

    typedef struct packed {
        logic [POS_W-1:0] pos_x;
        logic [POS_W-1:0] pos_y;
        logic [POS_W-1:0] pos_z;
    } item_t;

    typedef struct packed {
        logic [SUM_W-1:0]   distance_sum;
        logic [COUNT_W-1:0] cells_within;
    } result_t;

    typedef struct packed {
        item_t             pos;
        logic [GRID_W-1:0] n;
        logic              no_cells;
    } job_t;

    typedef struct packed {
        logic valid;
        logic last;
        logic hit;
    } tok_t;

    typedef enum logic [1:0] {
        SCAN_IDLE,
        SCAN_RUN,
        SCAN_DRAIN
    } scan_state_t;
endpackage
`default_nettype wire

// ===== rtl/particle_grid_distance_sum_core.sv =====
// top level of the particle grid distance sum block
// usage:
//   input channel: push / full carries one particle beat (pos_x, pos_y, pos_z,
//   unsigned Q0.16). a two-entry input queue takes beats while a scan runs.
//   result channel: empty / pop; the oldest result (distance_sum, cells_within)
//   sits on result while empty is low and leaves on pop.
//   config: write cfg_data to register cfg_index when cfg_we is high, only
//   while the block is idle; index 0 grid_cells, 1 cell_pitch, 2 rmax_squared.
// timing:
//   the scanner visits one grid cell per cycle, n^3 cells per particle with
//   n the grid size clipped to 64 (262144 cells at the default); each cell
//   then passes three distance stages and the 17-stage square root
//   pipeline before it is added to the particle's result.
//   an empty grid scans a single cell and yields zeros.
//   a new particle starts only after the previous one has fully drained.
//   the result register holds one finished beat; if it is not popped the
//   scanner waits before starting the next particle, and the input queue
//   fills and raises full.
// reset:
//   queues empty, scanner idle; registers at 64 cells, pitch 1/64, rmax^2 0.04
`default_nettype none
module particle_grid_distance_sum_core (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               push,
    output logic                                    full,
    input  wire pgds_pkg::item_t                    item,
    output logic                                    empty,
    input  wire logic                               pop,
    output pgds_pkg::result_t                       result,
    input  wire logic                               cfg_we,
    input  wire logic [pgds_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [pgds_pkg::CFG_DATA_W-1:0]    cfg_data
);
    import pgds_pkg::*;

    // configuration registers
    logic [GRID_W-1:0]  grid_cells_reg;
    logic [PITCH_W-1:0] cell_pitch_reg;
    logic [RMAX_W-1:0]  rmax_squared_reg;

    // queue between front and scanner
    logic job_valid;
    logic job_take;
    job_t job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            grid_cells_reg   <= GRID_RESET;
            cell_pitch_reg   <= PITCH_RESET;
            rmax_squared_reg <= RMAX_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_GRID_CELLS:   grid_cells_reg   <= cfg_data[GRID_W-1:0];
                CFG_CELL_PITCH:   cell_pitch_reg   <= cfg_data[PITCH_W-1:0];
                CFG_RMAX_SQUARED: rmax_squared_reg <= cfg_data[RMAX_W-1:0];
                default:          ; // unknown index: ignored
            endcase
        end
    end

    // front: accepts beats and saturates the grid size
    pgds_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .item       (item),
        .grid_cells (grid_cells_reg),
        .job_valid  (job_valid),
        .job        (job),
        .job_take   (job_take)
    );

    // back: walks the grid and owns the result register
    pgds_scan u_scan (
        .clk          (clk),
        .rst_n        (rst_n),
        .job_valid    (job_valid),
        .job          (job),
        .job_take     (job_take),
        .cell_pitch   (cell_pitch_reg),
        .rmax_squared (rmax_squared_reg),
        .empty        (empty),
        .pop          (pop),
        .result       (result)
    );
endmodule
`default_nettype wire

// ===== rtl/pgds_front.sv =====
// input queue: accepts particles and classifies the grid size for the scanner
`default_nettype none
module pgds_front (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      push,
    output logic                           full,
    input  wire pgds_pkg::item_t           item,
    input  wire logic [pgds_pkg::GRID_W-1:0] grid_cells,
    output logic                           job_valid,
    output pgds_pkg::job_t                 job,
    input  wire logic                      job_take
);
    import pgds_pkg::*;

    job_t       ent_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] cnt_reg, cnt_next;
    logic       enq, deq;
    job_t       new_job;

    assign full      = (cnt_reg == 2'd2);
    assign job_valid = (cnt_reg != 2'd0);
    assign job       = ent_reg[rd_ptr_reg];
    assign enq       = push && !full;
    assign deq       = job_take && job_valid;

    // saturate the grid size and flag an empty grid
    always_comb
    begin
        new_job.pos      = item;
        new_job.n        = (grid_cells > GRID_W'(MAX_GRID)) ? GRID_W'(MAX_GRID) : grid_cells;
        new_job.no_cells = (grid_cells == '0);
    end

    always_comb
    begin
        wr_ptr_next = enq ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = deq ? !rd_ptr_reg : rd_ptr_reg;
        cnt_next    = cnt_reg + {1'b0, enq} - {1'b0, deq};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (enq)
        begin
            ent_reg[wr_ptr_reg] <= new_job;
        end
    end
endmodule
`default_nettype wire

// ===== rtl/pgds_isqrt.sv =====
// pipelined floor square root, one result bit per stage
`default_nettype none
module pgds_isqrt (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire pgds_pkg::tok_t              in_tok,
    input  wire logic [pgds_pkg::RMAX_W-1:0] in_val,
    output pgds_pkg::tok_t                   out_tok,
    output logic [pgds_pkg::ROOT_W-1:0]      out_root
);
    import pgds_pkg::*;

    tok_t              tok_reg  [SQRT_STAGES];
    logic [RMAX_W-1:0] val_reg  [SQRT_STAGES];
    logic [REM_W-1:0]  rem_reg  [SQRT_STAGES];
    logic [ROOT_W-1:0] root_reg [SQRT_STAGES];

    for (genvar s = 0; s < SQRT_STAGES; s++)
    begin : g_stage
        tok_t              tok_i;
        logic [RMAX_W-1:0] val_i;
        logic [REM_W-1:0]  rem_i;
        logic [ROOT_W-1:0] root_i;
        logic [REM_W+1:0]  trial_rem;
        logic [REM_W+1:0]  trial_sub;

        if (s == 0)
        begin : g_first
            assign tok_i  = in_tok;
            assign val_i  = in_val;
            assign rem_i  = '0;
            assign root_i = '0;
        end
        else
        begin : g_rest
            assign tok_i  = tok_reg[s-1];
            assign val_i  = val_reg[s-1];
            assign rem_i  = rem_reg[s-1];
            assign root_i = root_reg[s-1];
        end

        assign trial_rem = {rem_i, val_i[RMAX_W-1-2*s -: 2]};
        assign trial_sub = (REM_W+2)'({root_i, 2'b01});

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                tok_reg[s] <= '0;
            end
            else
            begin
                tok_reg[s] <= tok_i;
            end
        end

        always_ff @(posedge clk)
        begin
            val_reg[s] <= val_i;
            if (trial_rem >= trial_sub)
            begin
                rem_reg[s]  <= REM_W'(trial_rem - trial_sub);
                root_reg[s] <= {root_i[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg[s]  <= REM_W'(trial_rem);
                root_reg[s] <= {root_i[ROOT_W-2:0], 1'b0};
            end
        end
    end

    assign out_tok  = tok_reg[SQRT_STAGES-1];
    assign out_root = root_reg[SQRT_STAGES-1];
endmodule
`default_nettype wire

// ===== rtl/pgds_scan.sv =====
// back end: grid scan, distance pipeline, accumulation and result register
`default_nettype none
module pgds_scan (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    input  wire logic                          job_valid,
    input  wire pgds_pkg::job_t                job,
    output logic                               job_take,
    input  wire logic [pgds_pkg::PITCH_W-1:0]  cell_pitch,
    input  wire logic [pgds_pkg::RMAX_W-1:0]   rmax_squared,
    output logic                               empty,
    input  wire logic                          pop,
    output pgds_pkg::result_t                  result
);
    import pgds_pkg::*;
    `include "particle_grid_distance_sum_core_assert.svh"

    scan_state_t       state_reg, state_next;
    job_t              job_reg;
    logic [IDX_W-1:0]  i_reg, j_reg, k_reg;
    logic [CTR_W-1:0]  cx_reg, cy_reg, cz_reg;
    logic [CTR_W-1:0]  pitch_ext, step;
    logic [GRID_W-1:0] nm1;
    logic              end_i, end_j, end_k, last_cell;
    logic              start, issue;

    // stage registers
    tok_t              s1_tok_reg, s2_tok_reg, s3_tok_reg;
    logic [DIFF_W-1:0] dx_reg, dy_reg, dz_reg;
    logic [SQ_W-1:0]   qx_reg, qy_reg, qz_reg;
    logic [RMAX_W-1:0] d_reg;
    logic [CTR_W-1:0]  ax, ay, az, ddx, ddy, ddz;
    logic              far;
    logic [SQ_W+1:0]   sq_sum;
    logic [SQ_W-1:0]   d_full;
    logic              in_range;

    tok_t              rt_tok;
    logic [ROOT_W-1:0] rt_root;
    logic [SUM_W-1:0]  sum_reg, sum_add;
    logic [COUNT_W-1:0] cnt_reg, cnt_add;
    logic              res_valid_reg;
    result_t           res_reg;

    assign pitch_ext = CTR_W'(cell_pitch);
    assign step      = CTR_W'({cell_pitch, 1'b0});
    assign nm1       = job_reg.n - GRID_W'(1);
    assign end_i     = ({1'b0, i_reg} == nm1);
    assign end_j     = ({1'b0, j_reg} == nm1);
    assign end_k     = ({1'b0, k_reg} == nm1);
    assign last_cell = job_reg.no_cells || (end_i && end_j && end_k);

    // state machine: next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            SCAN_IDLE:
            begin
                if (job_valid && !res_valid_reg)
                begin
                    state_next = SCAN_RUN;
                end
            end
            SCAN_RUN:
            begin
                if (last_cell)
                begin
                    state_next = SCAN_DRAIN;
                end
            end
            SCAN_DRAIN:
            begin
                if (rt_tok.valid && rt_tok.last)
                begin
                    state_next = SCAN_IDLE;
                end
            end
            default:
            begin
                state_next = SCAN_IDLE;
            end
        endcase
    end

    // state machine: outputs
    always_comb
    begin
        start = 1'b0;
        issue = 1'b0;
        case (state_reg)
            SCAN_IDLE:  start = job_valid && !res_valid_reg;
            SCAN_RUN:   issue = 1'b1;
            SCAN_DRAIN: issue = 1'b0;
            default:    issue = 1'b0;
        endcase
    end

    assign job_take = start;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= SCAN_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // cell counters, k fastest
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            job_reg <= job;
            i_reg   <= '0;
            j_reg   <= '0;
            k_reg   <= '0;
            cx_reg  <= pitch_ext;
            cy_reg  <= pitch_ext;
            cz_reg  <= pitch_ext;
        end
        else if (issue)
        begin
            if (end_k)
            begin
                k_reg  <= '0;
                cz_reg <= pitch_ext;
                if (end_j)
                begin
                    j_reg  <= '0;
                    cy_reg <= pitch_ext;
                    i_reg  <= i_reg + IDX_W'(1);
                    cx_reg <= cx_reg + step;
                end
                else
                begin
                    j_reg  <= j_reg + IDX_W'(1);
                    cy_reg <= cy_reg + step;
                end
            end
            else
            begin
                k_reg  <= k_reg + IDX_W'(1);
                cz_reg <= cz_reg + step;
            end
        end
    end

    // stage 1: axis differences against doubled positions
    assign ax  = CTR_W'({job_reg.pos.pos_x, 1'b0});
    assign ay  = CTR_W'({job_reg.pos.pos_y, 1'b0});
    assign az  = CTR_W'({job_reg.pos.pos_z, 1'b0});
    assign ddx = (ax > cx_reg) ? (ax - cx_reg) : (cx_reg - ax);
    assign ddy = (ay > cy_reg) ? (ay - cy_reg) : (cy_reg - ay);
    assign ddz = (az > cz_reg) ? (az - cz_reg) : (cz_reg - az);
    // an axis this far apart already exceeds any cutoff
    assign far = (|ddx[CTR_W-1:DIFF_W]) || (|ddy[CTR_W-1:DIFF_W]) ||
                 (|ddz[CTR_W-1:DIFF_W]) || job_reg.no_cells;

    // stage 3 logic: sum, scale to Q4.32 and compare with the Q2.32 cutoff
    assign sq_sum   = (SQ_W+2)'(qx_reg) + (SQ_W+2)'(qy_reg) + (SQ_W+2)'(qz_reg);
    assign d_full   = sq_sum[SQ_W+1:2];
    assign in_range = !s2_tok_reg.hit && (d_full < SQ_W'(rmax_squared));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_tok_reg <= '0;
            s2_tok_reg <= '0;
            s3_tok_reg <= '0;
        end
        else
        begin
            // hit in stages 1 and 2 carries the far flag
            s1_tok_reg <= '{valid: issue, last: issue && last_cell, hit: far};
            s2_tok_reg <= s1_tok_reg;
            s3_tok_reg <= '{valid: s2_tok_reg.valid, last: s2_tok_reg.last, hit: in_range};
        end
    end

    always_ff @(posedge clk)
    begin
        dx_reg <= ddx[DIFF_W-1:0];
        dy_reg <= ddy[DIFF_W-1:0];
        dz_reg <= ddz[DIFF_W-1:0];
        qx_reg <= dx_reg * dx_reg;
        qy_reg <= dy_reg * dy_reg;
        qz_reg <= dz_reg * dz_reg;
        d_reg  <= in_range ? d_full[RMAX_W-1:0] : '0;
    end

    pgds_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_tok   (s3_tok_reg),
        .in_val   (d_reg),
        .out_tok  (rt_tok),
        .out_root (rt_root)
    );

    // accumulate roots and hits
    assign sum_add = sum_reg + (rt_tok.hit ? SUM_W'(rt_root) : '0);
    assign cnt_add = cnt_reg + COUNT_W'(rt_tok.hit);

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sum_reg <= '0;
            cnt_reg <= '0;
        end
        else if (rt_tok.valid)
        begin
            sum_reg <= sum_add;
            cnt_reg <= cnt_add;
        end
        if (rt_tok.valid && rt_tok.last)
        begin
            res_reg.distance_sum <= sum_add;
            res_reg.cells_within <= cnt_add;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else if (rt_tok.valid && rt_tok.last)
        begin
            res_valid_reg <= 1'b1;
        end
        else if (pop)
        begin
            res_valid_reg <= 1'b0;
        end
    end

    assign empty  = !res_valid_reg;
    assign result = res_reg;

    `PGDS_ASSERT(a_start_only_when_free, !start || (!res_valid_reg && state_reg == SCAN_IDLE))
    `PGDS_ASSERT(a_issue_only_running, !s1_tok_reg.valid || state_reg != SCAN_IDLE)
    `PGDS_ASSERT(a_last_while_draining, !(rt_tok.valid && rt_tok.last) || state_reg == SCAN_DRAIN)
    `PGDS_ASSERT_NEXT(a_start_runs, start, state_reg == SCAN_RUN)
endmodule
`default_nettype wire
